FILE: src/psgd_pkg.sv
`timescale 1ns / 1ps

package psgd_pkg;

    // stream widths, the data widths padded to whole bytes
    localparam int S_DATA_W   = 72;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // result bit positions in the master tdata
    localparam int OUT_SHAKE_BIT = 0;
    localparam int OUT_ARMED_BIT = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLE_DIST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEGMENT_PX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_REVERSALS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GESTURE_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_GAP_MS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS        = 3'd5;

    // register defaults (min_sample_dist is kept squared)
    localparam logic [31:0] RST_MIN_DIST_SQ  = 32'd4;
    localparam logic [23:0] RST_MIN_SEGMENT  = 24'd40;
    localparam logic [3:0]  RST_REQ_REV      = 4'd3;
    localparam logic [31:0] RST_MAX_GESTURE  = 32'd800;
    localparam logic [31:0] RST_STALE_GAP    = 32'd150;
    localparam logic [31:0] RST_COOLDOWN     = 32'd1000;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2
    } axis_t;

endpackage

FILE: src/pointer_shake_gesture_detector.sv
`timescale 1ns / 1ps

// an accepted input beat passes the input register, then a single-pass update
//   into the result register, which holds its result beat
// throughput: one beat per cycle, limited only by the result side's tready
// reset (rst_n low, asynchronous): detector disarmed, gesture and position
//   state cleared, configuration registers back to their defaults

module pointer_shake_gesture_detector
    import psgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // input beats
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: pos_x[15:0], pos_y[31:16], pos_valid[32], now_ms[64:33], zero pad
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    // tuser: command[1:0]
    input  logic [S_USER_W-1:0]   s_axis_tuser,

    // result beats
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: shake[0], armed[1], zero pad
    output logic [M_DATA_W-1:0]   m_axis_tdata,

    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] min_dist_sq_reg;     // min_sample_dist squared
    logic [23:0] min_segment_reg;
    logic [3:0]  req_rev_reg;
    logic [31:0] max_gesture_reg;
    logic [31:0] stale_gap_reg;
    logic [31:0] cooldown_reg;

    // written distance, widened for squaring
    logic [31:0] cfg_dist;

    assign cfg_dist = {16'd0, cfg_data[15:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_sq_reg <= RST_MIN_DIST_SQ;
            min_segment_reg <= RST_MIN_SEGMENT;
            req_rev_reg     <= RST_REQ_REV;
            max_gesture_reg <= RST_MAX_GESTURE;
            stale_gap_reg   <= RST_STALE_GAP;
            cooldown_reg    <= RST_COOLDOWN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                // square once at write time so the sample path only compares
                CFG_MIN_SAMPLE_DIST:    min_dist_sq_reg <= cfg_dist * cfg_dist;
                CFG_MIN_SEGMENT_PX:     min_segment_reg <= cfg_data[23:0];
                CFG_REQUIRED_REVERSALS: req_rev_reg     <= cfg_data[3:0];
                CFG_MAX_GESTURE_MS:     max_gesture_reg <= cfg_data;
                CFG_STALE_GAP_MS:       stale_gap_reg   <= cfg_data;
                CFG_COOLDOWN_MS:        cooldown_reg    <= cfg_data;
                default:                ;   // indexes past the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: input register, result register
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [1:0]  in_cmd_reg;
    logic [15:0] in_x_reg;
    logic [15:0] in_y_reg;
    logic        in_pv_reg;
    logic [31:0] in_now_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_shake_reg;
    logic        out_armed_reg;

    logic        in_beat;
    logic        advance;

    // the held item moves on whenever the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_beat || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    // payload of the input register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            in_cmd_reg <= s_axis_tuser[1:0];
            in_x_reg   <= s_axis_tdata[15:0];
            in_y_reg   <= s_axis_tdata[31:16];
            in_pv_reg  <= s_axis_tdata[32];
            in_now_reg <= s_axis_tdata[64:33];
        end
    end

    // ------------------------------------------------------------------
    // detector state
    // ------------------------------------------------------------------
    logic        active_reg,      active_next;
    logic [15:0] prev_x_reg,      prev_x_next;
    logic [15:0] prev_y_reg,      prev_y_next;
    logic [31:0] prev_time_reg,   prev_time_next;
    axis_t       axis_reg,        axis_next;
    logic        dir_neg_reg,     dir_neg_next;
    logic [23:0] seg_reg,         seg_next;
    logic [3:0]  rev_reg,         rev_next;
    logic [31:0] gest_begin_reg,  gest_begin_next;
    logic [31:0] cd_end_reg,      cd_end_next;
    logic        shake_next;

    // ------------------------------------------------------------------
    // sample datapath
    // ------------------------------------------------------------------
    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] dx_neg;
    logic [16:0] dy_neg;
    logic [15:0] adx;
    logic [15:0] ady;
    logic [31:0] sq_x;
    logic [31:0] sq_y;
    logic [32:0] dist_sq;
    logic        too_short;

    logic        x_dom;
    axis_t       samp_axis;
    logic        samp_neg;
    logic [15:0] samp_mag;

    logic [31:0] gap;
    logic        stale;
    logic        cooling;

    // gesture state as seen after a possible stale-gap restart
    axis_t       axis_e;
    logic        dir_e;
    logic [23:0] seg_e;
    logic [3:0]  rev_e;
    logic [31:0] gb_e;

    logic [31:0] age;
    logic        too_old;
    logic [24:0] seg_sum;
    logic [23:0] seg_sat;
    logic [3:0]  rev_inc;
    logic        long_seg;
    logic        hit;
    cmd_t        cmd;

    // signed 16-bit differences in 17 bits, then magnitudes
    assign dx     = {in_x_reg[15], in_x_reg} - {prev_x_reg[15], prev_x_reg};
    assign dy     = {in_y_reg[15], in_y_reg} - {prev_y_reg[15], prev_y_reg};
    assign dx_neg = 17'd0 - dx;
    assign dy_neg = 17'd0 - dy;
    assign adx    = dx[16] ? dx_neg[15:0] : dx[15:0];
    assign ady    = dy[16] ? dy_neg[15:0] : dy[15:0];

    // integer stand-in for the hypot threshold: dx^2 + dy^2 < d^2
    assign sq_x      = {16'd0, adx} * {16'd0, adx};
    assign sq_y      = {16'd0, ady} * {16'd0, ady};
    assign dist_sq   = {1'b0, sq_x} + {1'b0, sq_y};
    assign too_short = dist_sq < {1'b0, min_dist_sq_reg};

    // dominant axis, ties go to x
    assign x_dom     = adx >= ady;
    assign samp_axis = x_dom ? AXIS_X : AXIS_Y;
    assign samp_neg  = x_dom ? dx[16] : dy[16];
    assign samp_mag  = x_dom ? adx : ady;

    // time compares, differences wrap modulo 2^32
    assign gap     = in_now_reg - prev_time_reg;
    assign stale   = gap > stale_gap_reg;
    assign cooling = in_now_reg < cd_end_reg;

    assign axis_e = stale ? AXIS_NONE  : axis_reg;
    assign dir_e  = stale ? 1'b0       : dir_neg_reg;
    assign seg_e  = stale ? 24'd0      : seg_reg;
    assign rev_e  = stale ? 4'd0       : rev_reg;
    assign gb_e   = stale ? in_now_reg : gest_begin_reg;

    assign age     = in_now_reg - gb_e;
    assign too_old = age > max_gesture_reg;

    // segment length and reversal count both saturate
    assign seg_sum  = {1'b0, seg_e} + {9'd0, samp_mag};
    assign seg_sat  = seg_sum[24] ? {24{1'b1}} : seg_sum[23:0];
    assign rev_inc  = (rev_e == 4'hF) ? rev_e : rev_e + 4'd1;
    assign long_seg = seg_e >= min_segment_reg;
    assign hit      = long_seg && (rev_inc >= req_rev_reg) && !too_old;

    assign cmd = cmd_t'(in_cmd_reg);

    always_comb
    begin
        active_next     = active_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_time_next  = prev_time_reg;
        axis_next       = axis_reg;
        dir_neg_next    = dir_neg_reg;
        seg_next        = seg_reg;
        rev_next        = rev_reg;
        gest_begin_next = gest_begin_reg;
        cd_end_next     = cd_end_reg;
        shake_next      = 1'b0;

        unique case (cmd)
            CMD_START:
            begin
                // arm, capture time and (if valid) position, clear gesture and cooldown
                active_next = 1'b1;
                if (in_pv_reg)
                begin
                    prev_x_next = in_x_reg;
                    prev_y_next = in_y_reg;
                end
                prev_time_next  = in_now_reg;
                axis_next       = AXIS_NONE;
                dir_neg_next    = 1'b0;
                seg_next        = 24'd0;
                rev_next        = 4'd0;
                gest_begin_next = 32'd0;
                cd_end_next     = 32'd0;
            end
            CMD_STOP:
            begin
                active_next = 1'b0;
            end
            CMD_SAMPLE:
            begin
                if (active_reg)
                begin
                    if (cooling)
                    begin
                        // cooldown: track position and time only
                        if (in_pv_reg)
                        begin
                            prev_x_next = in_x_reg;
                            prev_y_next = in_y_reg;
                        end
                        prev_time_next = in_now_reg;
                    end
                    else if (in_pv_reg)
                    begin
                        prev_x_next     = in_x_reg;
                        prev_y_next     = in_y_reg;
                        prev_time_next  = in_now_reg;
                        axis_next       = axis_e;
                        dir_neg_next    = dir_e;
                        seg_next        = seg_e;
                        rev_next        = rev_e;
                        gest_begin_next = gb_e;

                        if (!too_short)
                        begin
                            if (axis_e != samp_axis)
                            begin
                                // new axis starts a fresh gesture
                                axis_next       = samp_axis;
                                dir_neg_next    = samp_neg;
                                seg_next        = {8'd0, samp_mag};
                                rev_next        = 4'd0;
                                gest_begin_next = in_now_reg;
                            end
                            else if (hit && (samp_neg != dir_e))
                            begin
                                // shake: disarm and start the cooldown
                                rev_next    = rev_inc;
                                active_next = 1'b0;
                                cd_end_next = in_now_reg + cooldown_reg;
                                shake_next  = 1'b1;
                            end
                            else
                            begin
                                if (samp_neg == dir_e)
                                begin
                                    seg_next = seg_sat;
                                end
                                else
                                begin
                                    if (long_seg)
                                    begin
                                        rev_next = rev_inc;
                                    end
                                    dir_neg_next = samp_neg;
                                    seg_next     = {8'd0, samp_mag};
                                end
                                if (too_old)
                                begin
                                    axis_next       = AXIS_NONE;
                                    dir_neg_next    = 1'b0;
                                    seg_next        = 24'd0;
                                    rev_next        = 4'd0;
                                    gest_begin_next = in_now_reg;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
                // unused command code: no state change
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            active_reg     <= 1'b0;
            prev_x_reg     <= 16'd0;
            prev_y_reg     <= 16'd0;
            prev_time_reg  <= 32'd0;
            axis_reg       <= AXIS_NONE;
            dir_neg_reg    <= 1'b0;
            seg_reg        <= 24'd0;
            rev_reg        <= 4'd0;
            gest_begin_reg <= 32'd0;
            cd_end_reg     <= 32'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                active_reg     <= active_next;
                prev_x_reg     <= prev_x_next;
                prev_y_reg     <= prev_y_next;
                prev_time_reg  <= prev_time_next;
                axis_reg       <= axis_next;
                dir_neg_reg    <= dir_neg_next;
                seg_reg        <= seg_next;
                rev_reg        <= rev_next;
                gest_begin_reg <= gest_begin_next;
                cd_end_reg     <= cd_end_next;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_shake_reg <= shake_next;
            out_armed_reg <= active_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        m_axis_tdata                = '0;
        m_axis_tdata[OUT_SHAKE_BIT] = out_shake_reg;
        m_axis_tdata[OUT_ARMED_BIT] = out_armed_reg;
    end

endmodule

FILE: src/psgd_checker.sv
`timescale 1ns / 1ps

module psgd_checker
    import psgd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    // shake flag of the last delivered result beat
    logic last_shake_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_shake_reg <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            last_shake_reg <= m_axis_tdata[OUT_SHAKE_BIT];
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // a shake always disarms
    a_shake_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_SHAKE_BIT] |-> !m_axis_tdata[OUT_ARMED_BIT])
        else $error("shake reported while still armed");

    // two shakes never follow each other directly
    a_no_double_shake: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && last_shake_reg |-> !m_axis_tdata[OUT_SHAKE_BIT])
        else $error("shake right after a shake");

    // a draining result side never blocks input
    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while result side is ready");

endmodule

bind pointer_shake_gesture_detector psgd_checker u_psgd_checker (.*);

FILE: tb/sv/pointer_shake_gesture_detector_tb.sv
`timescale 1ns / 1ps

module pointer_shake_gesture_detector_tb;

    import psgd_pkg::*;

    // command code three has no enum member in the package; the block ignores it
    localparam logic [1:0]         CMD_IGNORED    = 2'd3;
    localparam logic signed [15:0] POS_MIN        = 16'sh8000;
    localparam logic signed [15:0] POS_MAX        = 16'sh7FFF;
    localparam int                 STALL_CYCLES   = 300;
    localparam int                 WATCHDOG_LIMIT = 2000;

    // shake and armed flags of one result beat
    typedef struct packed {
        logic shake;
        logic armed;
    } flags_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: pos_x[15:0], pos_y[31:16], pos_valid[32], now_ms[64:33], zero pad
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    // tuser: command[1:0]
    logic [S_USER_W-1:0]   s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: shake[0], armed[1], zero pad
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // flags of accepted input beats whose result beat is still to come
    flags_t      predicted_flags[$];
    int          mismatches     = 0;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    // toggled by the tests, the receiver process counts the stall itself
    logic        hold_toggle    = 1'b0;
    logic        hold_seen      = 1'b0;
    int          stall_left     = 0;
    // running millisecond clock carried in the input beats
    logic [31:0] clock_ms       = '0;

    // shadow of the detector state
    logic               det_armed;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic [31:0]        last_ms;
    axis_t              run_axis;
    logic               run_neg;
    logic [23:0]        run_len;
    logic [3:0]         rev_count;
    logic [31:0]        gesture_t0;
    logic [31:0]        cool_until;

    // shadow of the configuration registers
    logic [15:0]        min_dist_r;
    logic [23:0]        min_seg_r;
    logic [3:0]         req_rev_r;
    logic [31:0]        max_gesture_r;
    logic [31:0]        stale_gap_r;
    logic [31:0]        cooldown_r;

    pointer_shake_gesture_detector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // gesture predictor
    // ------------------------------------------------------------------

    function automatic void restart_gesture(logic [31:0] now);
        run_axis   = AXIS_NONE;
        run_neg    = 1'b0;
        run_len    = '0;
        rev_count  = '0;
        gesture_t0 = now;
    endfunction

    function automatic void reset_detector();
        min_dist_r    = 16'd2;
        min_seg_r     = RST_MIN_SEGMENT;
        req_rev_r     = RST_REQ_REV;
        max_gesture_r = RST_MAX_GESTURE;
        stale_gap_r   = RST_STALE_GAP;
        cooldown_r    = RST_COOLDOWN;
        det_armed     = 1'b0;
        last_x        = '0;
        last_y        = '0;
        last_ms       = '0;
        cool_until    = '0;
        restart_gesture('0);
    endfunction

    // one sample while armed; returns 1 when it completes a shake
    function automatic logic track_sample(logic signed [15:0] x, logic signed [15:0] y,
                                          logic valid, logic [31:0] now);
        int          dx, dy, adx, ady, delta, mag, run_sum;
        longint      dist_sq, floor_sq;
        axis_t       axis;
        logic        neg;
        logic [31:0] gap, age;

        // cooldown only follows the pointer
        if (now < cool_until)
        begin
            if (valid)
            begin
                last_x = x;
                last_y = y;
            end
            last_ms = now;
            return 1'b0;
        end
        // failed read leaves even the time stamp alone
        if (!valid)
            return 1'b0;

        dx = int'(x) - int'(last_x);
        dy = int'(y) - int'(last_y);
        last_x = x;
        last_y = y;

        gap = now - last_ms;
        if (gap > stale_gap_r)
            restart_gesture(now);
        last_ms = now;

        // squared distance compare stands in for the hypot threshold
        adx      = (dx < 0) ? -dx : dx;
        ady      = (dy < 0) ? -dy : dy;
        dist_sq  = longint'(adx) * longint'(adx) + longint'(ady) * longint'(ady);
        floor_sq = longint'(min_dist_r) * longint'(min_dist_r);
        if (dist_sq < floor_sq)
            return 1'b0;

        if (adx >= ady)
        begin
            delta = dx;
            axis  = AXIS_X;
        end
        else
        begin
            delta = dy;
            axis  = AXIS_Y;
        end
        neg = (delta < 0);
        mag = neg ? -delta : delta;

        // new dominant axis opens a fresh gesture
        if (run_axis != axis)
        begin
            run_axis   = axis;
            run_neg    = neg;
            run_len    = 24'(mag);
            rev_count  = '0;
            gesture_t0 = now;
            return 1'b0;
        end

        if (neg == run_neg)
        begin
            run_sum = int'(run_len) + mag;
            run_len = (run_sum > 24'hFF_FFFF) ? 24'hFF_FFFF : 24'(run_sum);
        end
        else
        begin
            if (run_len >= min_seg_r)
            begin
                if (rev_count != 4'd15)
                    rev_count = rev_count + 4'd1;
                age = now - gesture_t0;
                if (rev_count >= req_rev_r && age <= max_gesture_r)
                begin
                    det_armed  = 1'b0;
                    cool_until = now + cooldown_r;
                    return 1'b1;
                end
            end
            run_neg = neg;
            run_len = 24'(mag);
        end

        age = now - gesture_t0;
        if (age > max_gesture_r)
            restart_gesture(now);
        return 1'b0;
    endfunction

    function automatic flags_t predict_item(logic [1:0] cmd, logic signed [15:0] x,
                                            logic signed [15:0] y, logic valid,
                                            logic [31:0] now);
        flags_t r;

        r.shake = 1'b0;
        case (cmd)
            CMD_START:
            begin
                if (valid)
                begin
                    last_x = x;
                    last_y = y;
                end
                last_ms = now;
                restart_gesture('0);
                cool_until = '0;
                det_armed  = 1'b1;
            end
            CMD_STOP:
                det_armed = 1'b0;
            CMD_SAMPLE:
                if (det_armed)
                    r.shake = track_sample(x, y, valid, now);
            default: ;
        endcase
        r.armed = det_armed;
        return r;
    endfunction

    function automatic logic signed [15:0] clamp_pos(int v);
        if (v > 32767)
            return POS_MAX;
        if (v < -32768)
            return POS_MIN;
        return 16'(v);
    endfunction

    // ------------------------------------------------------------------
    // result side: ready pattern, long hold-off, checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen     <= hold_toggle;
            stall_left    <= STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        if (mismatches < 100)
            $display("%0t ns mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        flags_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (predicted_flags.size() == 0)
                report_mismatch("result beat with none pending", 8'h00, m_axis_tdata);
            else
            begin
                want = predicted_flags.pop_front();
                if (m_axis_tdata[OUT_SHAKE_BIT] !== want.shake)
                    report_mismatch("shake", 8'(want.shake), 8'(m_axis_tdata[OUT_SHAKE_BIT]));
                if (m_axis_tdata[OUT_ARMED_BIT] !== want.armed)
                    report_mismatch("armed", 8'(want.armed), 8'(m_axis_tdata[OUT_ARMED_BIT]));
            end
        end
    end

    // no beat on either side for too long means the block hung
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one input beat, holding valid until accepted, then predict it
    task automatic send_item(logic [1:0] cmd, logic signed [15:0] x, logic signed [15:0] y,
                             logic valid, logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_DATA_W'({now, valid, y, x});
        s_axis_tuser  <= S_USER_W'(cmd);
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted_flags.push_back(predict_item(cmd, x, y, valid, now));
    endtask

    // position along the gesture axis and across it, mapped onto x and y
    task automatic send_xy(logic [1:0] cmd, int along, int across, bit on_x, logic valid);
        if (on_x)
            send_item(cmd, clamp_pos(along), clamp_pos(across), valid, clock_ms);
        else
            send_item(cmd, clamp_pos(across), clamp_pos(along), valid, clock_ms);
    endtask

    // sender stops, waits for every result beat, then idles before returning
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (predicted_flags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_MIN_SAMPLE_DIST:    min_dist_r    = value[15:0];
            CFG_MIN_SEGMENT_PX:     min_seg_r     = value[23:0];
            CFG_REQUIRED_REVERSALS: req_rev_r     = value[3:0];
            CFG_MAX_GESTURE_MS:     max_gesture_r = value;
            CFG_STALE_GAP_MS:       stale_gap_r   = value;
            CFG_COOLDOWN_MS:        cooldown_r    = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // registers only change with the block idle
    task automatic apply_settings(logic [15:0] min_dist, logic [23:0] min_seg,
                                  logic [3:0] req_rev, logic [31:0] max_gesture,
                                  logic [31:0] stale_gap, logic [31:0] cooldown);
        drain_results();
        write_reg(CFG_MIN_SAMPLE_DIST, 32'(min_dist));
        write_reg(CFG_MIN_SEGMENT_PX, 32'(min_seg));
        write_reg(CFG_REQUIRED_REVERSALS, 32'(req_rev));
        write_reg(CFG_MAX_GESTURE_MS, max_gesture);
        write_reg(CFG_STALE_GAP_MS, stale_gap);
        write_reg(CFG_COOLDOWN_MS, cooldown);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // back-and-forth swings sized from the current thresholds, with some noise:
    // failed reads, random beats of any command and time, sub-threshold wiggles
    task automatic run_gestures(int count);
        int done, reach, span, lo, hi, along, across, goal, stop_at;
        int jit, gap_top, swings, s;
        bit on_x, split;

        done = 0;
        while (done < count)
        begin
            reach = (min_seg_r > 24'd65535) ? 65535 : int'(min_seg_r);
            if (int'(min_dist_r) > reach)
                reach = int'(min_dist_r);
            span = $urandom_range((reach * 3) / 4 + 1,
                                  (reach + reach / 2 + 20 > 65535) ? 65535
                                                                   : reach + reach / 2 + 20);
            if ($urandom_range(2) == 0 && reach > 0)
                span = reach;
            lo      = int'($urandom_range(65535 - span)) - 32768;
            hi      = lo + span;
            on_x    = 1'($urandom_range(1));
            split   = (span >= 2 * int'(min_dist_r) + 2) && ($urandom_range(2) == 0);
            jit     = (span / 8 > 40) ? 40 : span / 8;
            gap_top = (stale_gap_r > 32'd400) ? 400 : int'(stale_gap_r);
            along   = $urandom_range(1) ? lo : hi;
            across  = int'($urandom_range(65535)) - 32768;

            // now and then jump anywhere on the time line, wrap included
            if ($urandom_range(15) == 0)
                clock_ms = $urandom;
            send_xy(CMD_START, along, across, on_x, $urandom_range(15) != 0);
            done++;

            swings = $urandom_range(1, int'(req_rev_r) + 3);
            repeat (swings)
            begin
                goal = (along == lo) ? hi : lo;
                for (s = split ? 0 : 1; s < 2; s++)
                begin
                    stop_at  = (s == 0) ? along + (goal - along) / 2 : goal;
                    clock_ms = clock_ms + $urandom_range(gap_top + gap_top / 4 + 1);
                    case ($urandom_range(11))
                        0: send_item(CMD_SAMPLE, 16'($urandom), 16'($urandom), 1'b0, clock_ms);
                        1:
                        begin
                            if ($urandom_range(1))
                                clock_ms = $urandom;
                            send_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                                      1'($urandom_range(1)), clock_ms);
                        end
                        2: send_xy(CMD_SAMPLE, along + 1, across, on_x, 1'b1);
                        default:
                            send_xy(CMD_SAMPLE, stop_at,
                                    across + int'($urandom_range(2 * jit)) - jit, on_x, 1'b1);
                    endcase
                    along = stop_at;
                    done++;
                end
            end
            if ($urandom_range(3) == 0)
            begin
                send_xy(CMD_STOP, along, across, on_x, 1'b1);
                done++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked beats on the reset configuration
    task automatic test_directed_cases();
        // disarmed: sample, stop and the unused command only report armed low
        send_item(CMD_SAMPLE, 16'sd100, 16'sd100, 1'b1, 32'd5);
        send_item(CMD_STOP, 16'sd0, 16'sd0, 1'b1, 32'd6);
        send_item(CMD_IGNORED, -16'sd1, -16'sd1, 1'b1, 32'hFFFF_FFFF);
        // start with a failed read keeps the old position
        send_item(CMD_START, 16'sd1234, -16'sd1234, 1'b0, 32'd10);
        // full-scale swing on x, then straight back: a counted reversal
        send_item(CMD_SAMPLE, POS_MAX, 16'sd0, 1'b1, 32'd20);
        send_item(CMD_SAMPLE, POS_MIN, 16'sd0, 1'b1, 32'd30);
        // failed read while armed
        send_item(CMD_SAMPLE, 16'sd0, 16'sd0, 1'b0, 32'd40);
        // dominant motion moves to y
        send_item(CMD_SAMPLE, POS_MIN, POS_MAX, 1'b1, 32'd50);
        // one pixel of motion is under the distance floor
        send_item(CMD_SAMPLE, -16'sd32767, POS_MAX, 1'b1, 32'd60);
        // long silence restarts the gesture
        send_item(CMD_SAMPLE, 16'sd0, POS_MAX, 1'b1, 32'd1060);
        send_item(CMD_IGNORED, 16'sd0, 16'sd0, 1'b1, 32'd1061);
        // clean shake: three reversals of 50 px within the window
        send_item(CMD_START, 16'sd0, 16'sd0, 1'b1, 32'd2000);
        send_item(CMD_SAMPLE, 16'sd50, 16'sd0, 1'b1, 32'd2010);
        send_item(CMD_SAMPLE, 16'sd0, 16'sd0, 1'b1, 32'd2020);
        send_item(CMD_SAMPLE, 16'sd50, 16'sd0, 1'b1, 32'd2030);
        send_item(CMD_SAMPLE, 16'sd0, 16'sd0, 1'b1, 32'd2040);
        // disarmed after the shake
        send_item(CMD_SAMPLE, 16'sd50, 16'sd0, 1'b1, 32'd2050);
        // gesture across the wrap of the millisecond counter
        send_item(CMD_START, POS_MIN, POS_MIN, 1'b1, 32'hFFFF_FFC0);
        send_item(CMD_SAMPLE, -16'sd32708, POS_MIN, 1'b1, 32'hFFFF_FFE0);
        send_item(CMD_SAMPLE, POS_MIN, POS_MIN, 1'b1, 32'd8);
        send_item(CMD_SAMPLE, -16'sd32708, POS_MIN, 1'b1, 32'd20);
        // stop while armed, then a sample that is ignored
        send_item(CMD_STOP, 16'sd0, 16'sd0, 1'b1, 32'd30);
        send_item(CMD_SAMPLE, 16'sd10, 16'sd10, 1'b1, 32'd40);
        clock_ms = 32'd5000;
    endtask

    // lowest (one for the reversal count), highest and reset values of every register
    task automatic test_register_extremes();
        apply_settings(16'd0, 24'd0, 4'd1, 32'd0, 32'd0, 32'd0);
        run_gestures(80);
        apply_settings(16'hFFFF, 24'hFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF);
        run_gestures(80);
        apply_settings(16'd2, 24'd40, 4'd3, 32'd800, 32'd150, 32'd1000);
        run_gestures(80);
    endtask

    // big pushes that count, small steps back under the floor that do not:
    // the segment grows past 24 bits and must stick at all ones
    task automatic test_segment_saturation();
        int lap;

        apply_settings(16'd60000, 24'hFF_FFFF, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
        send_item(CMD_START, POS_MIN, 16'sd0, 1'b1, clock_ms);
        for (lap = 0; lap < 258; lap++)
        begin
            clock_ms = clock_ms + 32'd1;
            send_item(CMD_SAMPLE, POS_MAX, 16'sd0, 1'b1, clock_ms);
            clock_ms = clock_ms + 32'd1;
            send_item(CMD_SAMPLE, 16'sd0, 16'sd0, 1'b1, clock_ms);
            clock_ms = clock_ms + 32'd1;
            send_item(CMD_SAMPLE, POS_MIN, 16'sd0, 1'b1, clock_ms);
        end
        // one more push, then the full reversal that must count
        clock_ms = clock_ms + 32'd1;
        send_item(CMD_SAMPLE, POS_MAX, 16'sd0, 1'b1, clock_ms);
        clock_ms = clock_ms + 32'd1;
        send_item(CMD_SAMPLE, POS_MIN, 16'sd0, 1'b1, clock_ms);
    endtask

    // random thresholds, fresh ones after each run of at least 150 beats
    task automatic test_random_gestures(int count);
        int left;

        for (left = count; left > 0; left -= 150)
        begin
            apply_settings(16'($urandom_range(0, 6)), 24'($urandom_range(0, 200)),
                           4'($urandom_range(1, 6)), $urandom_range(150, 2000),
                           $urandom_range(20, 300), $urandom);
            run_gestures(150);
        end
    endtask

    // receiver holds off for a long stretch while beats keep coming,
    // so the block fills and stalls its input
    task automatic test_backpressure();
        hold_toggle <= ~hold_toggle;
        run_gestures(80);
        drain_results();
        hold_toggle <= ~hold_toggle;
        run_gestures(40);
    endtask

    initial
    begin
        reset_detector();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(35, 64);
        test_directed_cases();
        test_register_extremes();
        test_segment_saturation();

        set_idling(64, 35);
        test_random_gestures(600);

        set_idling(0, 0);
        test_random_gestures(450);
        test_backpressure();

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
src/psgd_pkg.sv
src/pointer_shake_gesture_detector.sv
src/psgd_checker.sv
tb/sv/pointer_shake_gesture_detector_tb.sv
